// ===== rtl/core/imf_pkg.sv =====
// Shared types, constants and helpers for the incremental murmur fingerprint unit.
// No dependencies.
package imf_pkg;

  localparam logic [31:0] MIX_MUL    = 32'h5bd1_e995;
  localparam int unsigned MIX_SHIFT  = 24;
  localparam logic [31:0] SEED_RESET = 32'h3dd3_b51a;

  localparam int unsigned ADDR_W     = 3;
  localparam logic [ADDR_W-1:0] REG_SEED_ADDR = 3'd0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_K1,
    S_K2,
    S_H,
    S_HX,
    S_FIN,
    S_FIN2,
    S_EMIT
  } seq_state_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] hash;
  } result_t;

  function automatic logic [31:0] swap32(input logic [31:0] x);
    swap32 = {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

// ===== rtl/core/incremental_murmur_fingerprint_unit.sv =====
// Top level of the incremental murmur fingerprint unit: config port, sequencer, output register.
// Depends on imf_pkg and imf_seq.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  action, data_byte, starts_piece
//   out      output     out_valid/out_stall  hash_value
//   cfg      input      APB                  seed_value at address 0
//
// A byte that does not complete a word is only stored; one that completes a word runs states
// K1, K2, H and HX, with three passes through the single shared 32x32 multiplier.
// A finish runs FIN, FIN2 and EMIT with bytes pending (only EMIT without), plus any wait for a free output.
// Reset loads the running hash from the reset seed and clears pending bytes; no clearing pass.
// A result waiting in the output register does not stop byte transfers.
module incremental_murmur_fingerprint_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          action,
  input  logic [7:0]                    data_byte,
  input  logic                          starts_piece,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [31:0]                   hash_value,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [imf_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic             seq_idle;
  logic             accept;
  logic             out_free;
  logic [31:0]      seed_value;
  imf_pkg::result_t result;

  assign pready   = 1'b1;
  assign in_stall = ~seq_idle;
  assign accept   = in_valid & ~in_stall;
  assign out_free = ~out_valid | ~out_stall;
  assign prdata   = (paddr == imf_pkg::REG_SEED_ADDR) ? seed_value : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_value <= imf_pkg::SEED_RESET;
    end else if (psel && penable && pwrite && pready && paddr == imf_pkg::REG_SEED_ADDR) begin
      seed_value <= pwdata;
    end
  end

  imf_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .action       (action),
    .data_byte    (data_byte),
    .starts_piece (starts_piece),
    .seed         (seed_value),
    .out_free     (out_free),
    .idle         (seq_idle),
    .result       (result)
  );

  // hold the result until its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.valid) begin
      hash_value <= result.hash;
    end
  end

endmodule

// ===== rtl/core/imf_mul.sv =====
// Shared multiplier by the mixing constant, product registered.
// Depends on imf_pkg.
module imf_mul (
  input  logic        clk,
  input  logic [31:0] operand,
  output logic [31:0] product
);

  logic [31:0] product_next;

  assign product_next = operand * imf_pkg::MIX_MUL;

  always_ff @(posedge clk) begin
    product <= product_next;
  end

endmodule

// ===== rtl/core/imf_seq.sv =====
// Sequencer and hash state: gathers bytes, mixes words through the shared multiplier.
// Depends on imf_pkg and imf_mul.
module imf_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic                 action,
  input  logic [7:0]           data_byte,
  input  logic                 starts_piece,
  input  logic [31:0]          seed,
  input  logic                 out_free,
  output logic                 idle,
  output imf_pkg::result_t     result
);

  imf_pkg::seq_state_t state, state_next;
  logic [31:0] running_hash, running_hash_next;
  logic [23:0] pending, pending_next;
  logic [1:0]  pcount, pcount_next;
  logic        split, split_next;
  logic [31:0] kreg, kreg_next;
  logic [31:0] operand;
  logic [31:0] product;
  logic        split_in;
  logic [31:0] word;

  imf_mul u_mul (
    .clk     (clk),
    .operand (operand),
    .product (product)
  );

  assign idle     = (state == imf_pkg::S_IDLE);
  assign split_in = split | (starts_piece & (pcount != 2'd0));
  assign word     = {pending, data_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= imf_pkg::S_IDLE;
      running_hash <= imf_pkg::SEED_RESET;
      pending      <= '0;
      pcount       <= '0;
      split        <= 1'b0;
    end else begin
      state        <= state_next;
      running_hash <= running_hash_next;
      pending      <= pending_next;
      pcount       <= pcount_next;
      split        <= split_next;
    end
  end

  always_ff @(posedge clk) begin
    kreg <= kreg_next;
  end

  always_comb begin
    state_next        = state;
    running_hash_next = running_hash;
    pending_next      = pending;
    pcount_next       = pcount;
    split_next        = split;
    kreg_next         = kreg;
    operand           = kreg;
    result.valid      = 1'b0;
    result.hash       = kreg;
    unique case (state)
      imf_pkg::S_IDLE: begin
        if (accept) begin
          if (action) begin
            if (pcount != 2'd0) begin
              state_next = imf_pkg::S_FIN;
            end else begin
              kreg_next  = running_hash;
              state_next = imf_pkg::S_EMIT;
            end
          end else if (pcount != 2'd3) begin
            pending_next = {pending[15:0], data_byte};
            pcount_next  = pcount + 2'd1;
            split_next   = split_in;
          end else begin
            kreg_next    = split_in ? word : imf_pkg::swap32(word);
            pending_next = '0;
            pcount_next  = '0;
            split_next   = 1'b0;
            state_next   = imf_pkg::S_K1;
          end
        end
      end
      imf_pkg::S_K1: begin
        operand    = kreg;
        state_next = imf_pkg::S_K2;
      end
      imf_pkg::S_K2: begin
        operand    = product ^ (product >> imf_pkg::MIX_SHIFT);
        state_next = imf_pkg::S_H;
      end
      imf_pkg::S_H: begin
        kreg_next  = product;
        operand    = running_hash;
        state_next = imf_pkg::S_HX;
      end
      imf_pkg::S_HX: begin
        running_hash_next = product ^ kreg;
        state_next        = imf_pkg::S_IDLE;
      end
      imf_pkg::S_FIN: begin
        operand    = running_hash ^ {8'd0, pending};
        state_next = imf_pkg::S_FIN2;
      end
      imf_pkg::S_FIN2: begin
        kreg_next  = product;
        state_next = imf_pkg::S_EMIT;
      end
      imf_pkg::S_EMIT: begin
        if (out_free) begin
          result.valid      = 1'b1;
          running_hash_next = seed;
          pending_next      = '0;
          pcount_next       = '0;
          split_next        = 1'b0;
          state_next        = imf_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = imf_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/imf_checker.sv =====
// Port-level checks for the incremental murmur fingerprint unit, bound to the top level.
// Depends on incremental_murmur_fingerprint_unit.
module imf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        action,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] hash_value
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("outputs not quiet after reset");

  a_finish_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && action |=> in_stall)
    else $error("finish transfer did not hold off input");

  a_byte_no_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !action && !(out_valid && out_stall) |=> !out_valid)
    else $error("result appeared after a byte transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(hash_value))
    else $error("stalled result changed");

endmodule

bind incremental_murmur_fingerprint_unit imf_checker u_imf_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .action     (action),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .hash_value (hash_value)
);
